/* hw/rtl/mrfr_pkg.sv */
`timescale 1ns / 1ps
package mrfr_pkg;

  // actions carried by one input transaction
  localparam logic [2:0] ACT_WRITE   = 3'd0;
  localparam logic [2:0] ACT_READ    = 3'd1;
  localparam logic [2:0] ACT_ATTACH  = 3'd2;
  localparam logic [2:0] ACT_RELEASE = 3'd3;
  localparam logic [2:0] ACT_RESET   = 3'd4;
  localparam logic [2:0] ACT_QUERY   = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_DATA = 3'd1;
  localparam logic [2:0] ST_NO_CAP  = 3'd2;
  localparam logic [2:0] ST_BAD_IDX = 3'd3;
  localparam logic [2:0] ST_NO_SLOT = 3'd4;

  localparam logic [31:0] MAGIC_WORD = 32'hffefface;

  // header word offsets
  localparam logic [3:0] W_MAGIC = 4'd0;
  localparam logic [3:0] W_TYPE  = 4'd1;
  localparam logic [3:0] W_PAD   = 4'd2;
  localparam logic [3:0] W_UNUSED = 4'd3;
  localparam logic [3:0] W_TS_LO = 4'd4;
  localparam logic [3:0] W_TS_HI = 4'd5;
  localparam logic [3:0] W_LEN   = 4'd6;
  localparam logic [3:0] W_PLAY  = 4'd7;
  localparam logic [3:0] W_TAG_LO = 4'd8;
  localparam logic [3:0] W_TAG_HI = 4'd9;
  localparam logic [3:0] W_PREV  = 4'd10;
  localparam logic [3:0] W_NEXT  = 4'd11;
  localparam int HDR_WORDS = 12;

  // header store access request
  typedef struct packed {
    logic        we;
    logic [3:0]  word;
    logic [31:0] wdata;
  } mem_req_t;

endpackage

/* hw/rtl/mrfr_hdr_store.sv */
`timescale 1ns / 1ps
module mrfr_hdr_store #(
  parameter int BUF_BYTES = 65536,
  parameter int POS_W     = 18
) (
  input  logic              clk,
  input  logic [POS_W-1:0]  pos,
  input  mrfr_pkg::mem_req_t req,
  output logic [31:0]       rdata
);
  import mrfr_pkg::*;

  localparam int STORE_WORDS = BUF_BYTES / 4;
  localparam int AW = $clog2(STORE_WORDS);

  logic [31:0]      mem [STORE_WORDS];
  logic [POS_W-1:0] wide;
  logic             oob;
  logic [AW-1:0]    addr;
  logic [31:0]      rd_q_r;
  logic             oob_r;

  // word address and ring bound check
  always_comb begin
    wide = (pos >> 2) + POS_W'(req.word);
    oob  = wide >= POS_W'(STORE_WORDS);
    addr = wide[AW-1:0];
  end

  // one write or read per cycle, registered read data
  always_ff @(posedge clk) begin
    if (req.we && !oob) begin
      mem[addr] <= req.wdata;
    end
    rd_q_r <= mem[addr];
    oob_r  <= oob;
  end

  // words past the ring read as zero
  assign rdata = oob_r ? 32'd0 : rd_q_r;

endmodule

/* hw/rtl/multi_reader_frame_ring_top.sv */
`timescale 1ns / 1ps
// Frame ring with one writer and up to READERS readers.
// Input channel (in_valid / in_stall) carries one action per transaction:
// write frame header, read frame, attach, release, reset ring, query counts.
// Each transaction gives exactly one result on the output channel
// (out_valid / out_stall), held stable while out_stall is high.
// A write runs a scan step, then steps through the twelve header word slots
// into the store (the unused word is not written), then hands off; a read
// fetches the header, walks back one frame at a time on a resync, and
// fetches the frame at 0 when a bad header falls back to it. The
// single-port header store takes one 32-bit word per cycle;
// one action is worked on at a time, and the next is taken while the
// previous result still waits in the output register.
// When the receiver stalls, a finished result waits in the DONE state and
// no further action completes until the output register frees.
// cfg_valid / cfg_ready writes keyframe_type; write it only while idle.
// Reset (rst_n low, synchronous) empties the ring, detaches all readers and
// sets keyframe_type to 1; the header store itself is not cleared.
module multi_reader_frame_ring_top #(
  parameter int BUF_BYTES    = 65536,
  parameter int READERS      = 16,
  parameter int HEADER_BYTES = 48
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_reader,
  input  logic [15:0] in_frame_len,
  input  logic [7:0]  in_ftype,
  input  logic [63:0] in_timestamp,
  input  logic [31:0] in_playtime,
  input  logic [39:0] in_codec_tag,
  input  logic [16:0] in_read_capacity,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_payload_addr,
  output logic [15:0] out_real_len,
  output logic [7:0]  out_type,
  output logic [63:0] out_timestamp,
  output logic [31:0] out_playtime,
  output logic [39:0] out_codec_tag,
  output logic [3:0]  out_assigned_reader,
  output logic [31:0] out_write_count,
  output logic [31:0] out_read_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);
  import mrfr_pkg::*;

  localparam int POS_W  = $clog2(BUF_BYTES + 131072);
  localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_WR_SCAN, S_WR_HDR, S_RD_START, S_RD_FETCH,
    S_RD_WAIT, S_RD_WALK, S_RD_EVAL, S_DONE
  } state_t;

  state_t             state_r;
  logic [2:0]         act_r;
  logic [RIDX_W-1:0]  rsel_r;
  logic               rok_r;
  logic [15:0]        len_r;
  logic [7:0]         ftype_r;
  logic [63:0]        ts_r;
  logic [31:0]        pt_r;
  logic [39:0]        tag_r;
  logic [16:0]        cap_r;
  logic [7:0]         kf_r;

  logic [POS_W-1:0]   wp_r;
  logic [POS_W-1:0]   np_r;
  logic [31:0]        fw_r;
  logic [POS_W-1:0]   rpos_r [READERS];
  logic [31:0]        rseq_r [READERS];
  logic               resync_r [READERS];
  logic               busy_r [READERS];

  logic [POS_W-1:0]   cur_pos_r;
  logic [3:0]         k_r;
  logic               rd_pend_r;
  logic [3:0]         rd_k_r;
  logic [31:0]        hdr_r [HDR_WORDS];
  logic [31:0]        seq_w_r;
  logic [31:0]        walk_n_r;
  logic               walk_r;

  logic [2:0]         res_status_r;
  logic [15:0]        res_addr_r;
  logic [15:0]        res_len_r;
  logic [7:0]         res_type_r;
  logic [63:0]        res_ts_r;
  logic [31:0]        res_pt_r;
  logic [39:0]        res_tag_r;
  logic [3:0]         res_asg_r;

  logic               out_valid_r;
  logic [2:0]         out_status_r;
  logic [15:0]        out_addr_r;
  logic [15:0]        out_len_r;
  logic [7:0]         out_type_r;
  logic [63:0]        out_ts_r;
  logic [31:0]        out_pt_r;
  logic [39:0]        out_tag_r;
  logic [3:0]         out_asg_r;
  logic [31:0]        out_wc_r;
  logic [31:0]        out_rc_r;

  mem_req_t           req;
  logic [31:0]        rdata;
  logic               in_fire;
  logic               in_rok;
  logic [16:0]        padded;
  logic [39:0]        tag_m;
  logic               tag_end;
  logic [POS_W-1:0]   len_ext;
  logic [POS_W-1:0]   hb_ext;
  logic [POS_W-1:0]   wr_pos;
  logic [POS_W-1:0]   nxt_pos;
  logic               slot_found;
  logic [RIDX_W-1:0]  slot_idx;
  logic [POS_W-1:0]   prev_pos;
  logic               kf_hit;

  mrfr_hdr_store #(
    .BUF_BYTES(BUF_BYTES),
    .POS_W    (POS_W)
  ) u_store (
    .clk  (clk),
    .pos  (cur_pos_r),
    .req  (req),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign in_rok    = int'(in_reader) < READERS;

  // frame geometry for the write
  always_comb begin
    padded  = (17'(len_r) + 17'd3) & ~17'd3;
    len_ext = POS_W'(len_r);
    hb_ext  = POS_W'(HEADER_BYTES);
    if ((wp_r + hb_ext > POS_W'(BUF_BYTES)) || (wp_r + hb_ext + len_ext > POS_W'(BUF_BYTES))) begin
      wr_pos = '0;
    end else begin
      wr_pos = wp_r;
    end
    nxt_pos = cur_pos_r + hb_ext + POS_W'(padded);
  end

  // codec tag keeps bytes up to the first zero byte
  always_comb begin
    tag_m   = '0;
    tag_end = 1'b0;
    for (int i = 0; i < 5; i++) begin
      if (tag_r[8*i +: 8] == 8'd0) begin
        tag_end = 1'b1;
      end
      if (!tag_end) begin
        tag_m[8*i +: 8] = tag_r[8*i +: 8];
      end
    end
  end

  // lowest free reader slot
  always_comb begin
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = READERS - 1; i >= 0; i--) begin
      if (!busy_r[i]) begin
        slot_found = 1'b1;
        slot_idx   = RIDX_W'(i);
      end
    end
  end

  assign prev_pos = hdr_r[W_PREV][POS_W-1:0];
  assign kf_hit   = (hdr_r[W_TYPE][7:0] == kf_r) && (hdr_r[W_MAGIC] == MAGIC_WORD);

  // header store request
  always_comb begin
    req.we    = (state_r == S_WR_HDR) && (k_r != W_UNUSED);
    req.word  = k_r;
    req.wdata = '0;
    unique case (k_r)
      W_MAGIC:  req.wdata = MAGIC_WORD;
      W_TYPE:   req.wdata = {24'd0, ftype_r};
      W_PAD:    req.wdata = 32'(padded);
      W_TS_LO:  req.wdata = ts_r[31:0];
      W_TS_HI:  req.wdata = ts_r[63:32];
      W_LEN:    req.wdata = {16'd0, len_r};
      W_PLAY:   req.wdata = pt_r;
      W_TAG_LO: req.wdata = tag_m[31:0];
      W_TAG_HI: req.wdata = {24'd0, tag_m[39:32]};
      W_PREV:   req.wdata = 32'(np_r);
      W_NEXT:   req.wdata = 32'(nxt_pos);
      default:  req.wdata = '0;
    endcase
  end

  // control state machine and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      kf_r        <= 8'd1;
      wp_r        <= '0;
      np_r        <= '0;
      fw_r        <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      walk_r      <= 1'b0;
      for (int i = 0; i < READERS; i++) begin
        rpos_r[i]   <= '0;
        rseq_r[i]   <= '0;
        resync_r[i] <= 1'b0;
        busy_r[i]   <= 1'b0;
      end
    end else begin
      if (cfg_valid) begin
        kf_r <= cfg_data;
      end
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= (state_r == S_RD_FETCH);
      if (rd_pend_r) begin
        hdr_r[rd_k_r] <= rdata;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            act_r        <= in_action;
            rsel_r       <= RIDX_W'(in_reader);
            rok_r        <= in_rok;
            len_r        <= in_frame_len;
            ftype_r      <= in_ftype;
            ts_r         <= in_timestamp;
            pt_r         <= in_playtime;
            tag_r        <= in_codec_tag;
            cap_r        <= in_read_capacity;
            res_status_r <= ST_OK;
            res_addr_r   <= '0;
            res_len_r    <= '0;
            res_type_r   <= '0;
            res_ts_r     <= '0;
            res_pt_r     <= '0;
            res_tag_r    <= '0;
            res_asg_r    <= '0;
            priority case (1'b1)
              in_action == ACT_WRITE: state_r <= S_WR_SCAN;
              in_action == ACT_READ && in_rok: state_r <= S_RD_START;
              default: state_r <= S_EXEC;
            endcase
          end
        end

        S_EXEC: begin
          unique case (act_r)
            ACT_READ, ACT_QUERY: begin
              if (!rok_r) res_status_r <= ST_BAD_IDX;
            end
            ACT_RELEASE: begin
              if (rok_r) begin
                busy_r[rsel_r] <= 1'b0;
              end else begin
                res_status_r <= ST_BAD_IDX;
              end
            end
            ACT_ATTACH: begin
              if (slot_found) begin
                busy_r[slot_idx]   <= 1'b1;
                resync_r[slot_idx] <= 1'b1;
                res_asg_r          <= 4'(slot_idx);
              end else begin
                res_status_r <= ST_NO_SLOT;
              end
            end
            ACT_RESET: begin
              wp_r <= '0;
              np_r <= '0;
              fw_r <= '0;
              for (int i = 0; i < READERS; i++) begin
                rpos_r[i]   <= '0;
                rseq_r[i]   <= '0;
                resync_r[i] <= 1'b0;
              end
            end
            default: ;
          endcase
          state_r <= S_DONE;
        end

        // place the frame and flag overrun readers
        S_WR_SCAN: begin
          cur_pos_r <= wr_pos;
          for (int i = 0; i < READERS; i++) begin
            if (wr_pos < rpos_r[i] && wr_pos + hb_ext + len_ext > rpos_r[i]) begin
              resync_r[i] <= 1'b1;
            end
          end
          k_r     <= '0;
          state_r <= S_WR_HDR;
        end

        // one header word per cycle
        S_WR_HDR: begin
          k_r <= k_r + 4'd1;
          if (k_r == W_NEXT) begin
            np_r       <= cur_pos_r;
            fw_r       <= fw_r + 32'd1;
            wp_r       <= nxt_pos;
            res_addr_r <= 16'(cur_pos_r + hb_ext);
            state_r    <= S_DONE;
          end
        end

        S_RD_START: begin
          k_r <= '0;
          priority if (rpos_r[rsel_r] == wp_r) begin
            res_status_r <= ST_NO_DATA;
            state_r      <= S_DONE;
          end else if (resync_r[rsel_r] && fw_r == 32'd0) begin
            rseq_r[rsel_r] <= fw_r - 32'd1;
            res_status_r   <= ST_NO_DATA;
            state_r        <= S_DONE;
          end else if (resync_r[rsel_r]) begin
            cur_pos_r <= np_r;
            seq_w_r   <= fw_r - 32'd1;
            walk_n_r  <= '0;
            walk_r    <= 1'b1;
            state_r   <= S_RD_FETCH;
          end else begin
            cur_pos_r <= rpos_r[rsel_r];
            walk_r    <= 1'b0;
            state_r   <= S_RD_FETCH;
          end
        end

        // stream the header words in, one per cycle
        S_RD_FETCH: begin
          rd_k_r    <= k_r;
          k_r       <= k_r + 4'd1;
          if (k_r == W_NEXT) begin
            state_r <= S_RD_WAIT;
          end
        end

        S_RD_WAIT: begin
          state_r <= walk_r ? S_RD_WALK : S_RD_EVAL;
        end

        // one hop of the keyframe search
        S_RD_WALK: begin
          priority if (kf_hit) begin
            rseq_r[rsel_r]   <= seq_w_r;
            resync_r[rsel_r] <= 1'b0;
            walk_r           <= 1'b0;
            state_r          <= S_RD_EVAL;
          end else if (cur_pos_r == '0 && hdr_r[W_PREV] == 32'd0) begin
            rseq_r[rsel_r] <= seq_w_r;
            res_status_r   <= ST_NO_DATA;
            walk_r         <= 1'b0;
            state_r        <= S_DONE;
          end else if (walk_n_r + 32'd1 < fw_r) begin
            cur_pos_r <= prev_pos;
            seq_w_r   <= seq_w_r - 32'd1;
            walk_n_r  <= walk_n_r + 32'd1;
            k_r       <= '0;
            state_r   <= S_RD_FETCH;
          end else begin
            rseq_r[rsel_r] <= seq_w_r - 32'd1;
            res_status_r   <= ST_NO_DATA;
            walk_r         <= 1'b0;
            state_r        <= S_DONE;
          end
        end

        // fall back to the frame at 0, then check capacity
        S_RD_EVAL: begin
          priority if (hdr_r[W_MAGIC] != MAGIC_WORD && cur_pos_r != '0) begin
            cur_pos_r <= '0;
            k_r       <= '0;
            state_r   <= S_RD_FETCH;
          end else if (32'(cap_r) < hdr_r[W_PAD]) begin
            res_status_r <= ST_NO_CAP;
            state_r      <= S_DONE;
          end else begin
            res_addr_r     <= 16'(cur_pos_r + hb_ext);
            res_len_r      <= hdr_r[W_LEN][15:0];
            res_type_r     <= hdr_r[W_TYPE][7:0];
            res_ts_r       <= {hdr_r[W_TS_HI], hdr_r[W_TS_LO]};
            res_pt_r       <= hdr_r[W_PLAY];
            res_tag_r      <= {hdr_r[W_TAG_HI][7:0], hdr_r[W_TAG_LO]};
            rpos_r[rsel_r] <= hdr_r[W_NEXT][POS_W-1:0];
            rseq_r[rsel_r] <= rseq_r[rsel_r] + 32'd1;
            state_r        <= S_DONE;
          end
        end

        // hand the result to the output register
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_addr_r   <= res_addr_r;
            out_len_r    <= res_len_r;
            out_type_r   <= res_type_r;
            out_ts_r     <= res_ts_r;
            out_pt_r     <= res_pt_r;
            out_tag_r    <= res_tag_r;
            out_asg_r    <= res_asg_r;
            out_wc_r     <= fw_r;
            out_rc_r     <= rok_r ? rseq_r[rsel_r] : 32'd0;
            state_r      <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_payload_addr    = out_addr_r;
  assign out_real_len        = out_len_r;
  assign out_type            = out_type_r;
  assign out_timestamp       = out_ts_r;
  assign out_playtime        = out_pt_r;
  assign out_codec_tag       = out_tag_r;
  assign out_assigned_reader = out_asg_r;
  assign out_write_count     = out_wc_r;
  assign out_read_count      = out_rc_r;

  // keyframe walk stays within the stored frame count
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_RD_WALK |-> walk_n_r < fw_r)
    else $error("keyframe walk past frame count");

  // a stored frame always leaves the write position past one header
  a_wp_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    fw_r != 32'd0 |-> wp_r >= hb_ext)
    else $error("write position behind stored frame");

  // results only come out of the handoff state
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result without completed transaction");

  // header words are written only while storing a frame
  a_store_write: assert property (@(posedge clk) disable iff (!rst_n)
    req.we |-> state_r == S_WR_HDR && !rd_pend_r)
    else $error("store write outside frame write");

endmodule

/* test/tb_multi_reader_frame_ring_top.sv */
`timescale 1ns / 1ps
module tb_multi_reader_frame_ring_top;
  import mrfr_pkg::*;

  localparam int          RING_BYTES  = 65536;
  localparam int          SLOTS       = 16;
  localparam int          HDR_BYTES   = 48;
  localparam int          STORE_WORDS = RING_BYTES / 4;
  localparam logic [31:0] FRAME_MAGIC = 32'hffefface;
  localparam int          HOLD_CYCLES = 300;

  typedef struct {
    logic [2:0]  action;
    logic [3:0]  reader;
    logic [15:0] frame_len;
    logic [7:0]  ftype;
    logic [63:0] timestamp;
    logic [31:0] playtime;
    logic [39:0] codec_tag;
    logic [16:0] read_capacity;
  } ring_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] payload_addr;
    logic [15:0] real_len;
    logic [7:0]  ftype;
    logic [63:0] timestamp;
    logic [31:0] playtime;
    logic [39:0] codec_tag;
    logic [3:0]  assigned_reader;
    logic [31:0] write_count;
    logic [31:0] read_count;
  } ring_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_action;
  logic [3:0]  in_reader;
  logic [15:0] in_frame_len;
  logic [7:0]  in_ftype;
  logic [63:0] in_timestamp;
  logic [31:0] in_playtime;
  logic [39:0] in_codec_tag;
  logic [16:0] in_read_capacity;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [15:0] out_payload_addr;
  logic [15:0] out_real_len;
  logic [7:0]  out_type;
  logic [63:0] out_timestamp;
  logic [31:0] out_playtime;
  logic [39:0] out_codec_tag;
  logic [3:0]  out_assigned_reader;
  logic [31:0] out_write_count;
  logic [31:0] out_read_count;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  multi_reader_frame_ring_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_action(in_action), .in_reader(in_reader), .in_frame_len(in_frame_len),
    .in_ftype(in_ftype), .in_timestamp(in_timestamp),
    .in_playtime(in_playtime), .in_codec_tag(in_codec_tag),
    .in_read_capacity(in_read_capacity),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_status(out_status), .out_payload_addr(out_payload_addr),
    .out_real_len(out_real_len), .out_type(out_type),
    .out_timestamp(out_timestamp), .out_playtime(out_playtime),
    .out_codec_tag(out_codec_tag), .out_assigned_reader(out_assigned_reader),
    .out_write_count(out_write_count), .out_read_count(out_read_count),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // shadow copy of the ring state
  bit [31:0]   hdr_mem [int];
  int unsigned rd_pos [SLOTS];
  bit [31:0]   rd_seq [SLOTS];
  bit          rd_resync [SLOTS];
  bit          slot_taken [SLOTS];
  int unsigned wr_pos;
  int unsigned newest;
  bit [31:0]   frames_done;
  bit [7:0]    keyframe_code;

  ring_result_t expected_results [$];
  int           mismatch_count;
  bit           calm;
  bit           hold_req;

  always #5 clk = ~clk;

  // header word lookup; flags a word that was never stored
  function automatic bit [31:0] hdr_peek(int unsigned pos, int word, inout bit unknown);
    int unsigned w;
    w = (pos >> 2) + word;
    if (w >= STORE_WORDS) return 32'd0;
    if (!hdr_mem.exists(w)) begin
      unknown = 1'b1;
      return 32'd0;
    end
    return hdr_mem[w];
  endfunction

  function automatic void hdr_poke(int unsigned pos, int word, bit [31:0] v);
    int unsigned w;
    w = (pos >> 2) + word;
    if (w < STORE_WORDS) hdr_mem[w] = v;
  endfunction

  function automatic void ring_clear();
    for (int i = 0; i < SLOTS; i++) begin
      rd_pos[i] = 0;
      rd_seq[i] = 0;
      rd_resync[i] = 0;
    end
    wr_pos = 0;
    newest = 0;
    frames_done = 0;
  endfunction

  function automatic void frame_store(ring_item_t it, ref ring_result_t res);
    int unsigned pos, len, padded;
    bit [39:0]   tag;
    pos = wr_pos;
    len = it.frame_len;
    padded = (len + 3) & ~32'd3;
    tag = '0;
    if (pos + HDR_BYTES > RING_BYTES || pos + HDR_BYTES + len > RING_BYTES) pos = 0;
    for (int i = 0; i < SLOTS; i++)
      if (pos < rd_pos[i] && pos + HDR_BYTES + len > rd_pos[i]) rd_resync[i] = 1'b1;
    // codec bytes stop at the first zero byte
    for (int i = 0; i < 5; i++) begin
      if (it.codec_tag[8*i +: 8] == 8'd0) break;
      tag[8*i +: 8] = it.codec_tag[8*i +: 8];
    end
    hdr_poke(pos, W_MAGIC, FRAME_MAGIC);
    hdr_poke(pos, W_TYPE, {24'd0, it.ftype});
    hdr_poke(pos, W_PAD, padded);
    hdr_poke(pos, W_TS_LO, it.timestamp[31:0]);
    hdr_poke(pos, W_TS_HI, it.timestamp[63:32]);
    hdr_poke(pos, W_LEN, len);
    hdr_poke(pos, W_PLAY, it.playtime);
    hdr_poke(pos, W_TAG_LO, tag[31:0]);
    hdr_poke(pos, W_TAG_HI, {24'd0, tag[39:32]});
    hdr_poke(pos, W_PREV, newest);
    hdr_poke(pos, W_NEXT, pos + HDR_BYTES + padded);
    newest = pos;
    frames_done++;
    wr_pos = pos + HDR_BYTES + padded;
    res.status = ST_OK;
    res.payload_addr = 16'(pos + HDR_BYTES);
  endfunction

  // frame read worked out on locals; state is committed only when every
  // header word it touches is known
  function automatic bit frame_fetch(int r, ring_item_t it, ref ring_result_t res);
    int unsigned pos, prev, k;
    bit [31:0]   seq;
    bit          rs, found, unknown;
    bit [31:0]   pad;
    pos = rd_pos[r];
    seq = rd_seq[r];
    rs = rd_resync[r];
    unknown = 0;
    if (pos == wr_pos) begin
      res.status = ST_NO_DATA;
      return 1'b1;
    end
    if (rs) begin
      seq = frames_done - 1;
      k = 0;
      found = 0;
      pos = newest;
      while (k < frames_done) begin
        prev = hdr_peek(pos, W_PREV, unknown);
        k++;
        if (hdr_peek(pos, W_TYPE, unknown) == {24'd0, keyframe_code} &&
            hdr_peek(pos, W_MAGIC, unknown) == FRAME_MAGIC) begin
          found = 1;
          break;
        end
        if (pos == 0 && prev == 0) break;
        pos = prev;
        seq--;
      end
      if (unknown) return 1'b0;
      if (!found) begin
        rd_seq[r] = seq;
        res.status = ST_NO_DATA;
        return 1'b1;
      end
      rs = 0;
    end
    if (hdr_peek(pos, W_MAGIC, unknown) != FRAME_MAGIC) pos = 0;
    pad = hdr_peek(pos, W_PAD, unknown);
    if (unknown) return 1'b0;
    if ({15'd0, it.read_capacity} < pad) begin
      rd_seq[r] = seq;
      rd_resync[r] = rs;
      res.status = ST_NO_CAP;
      return 1'b1;
    end
    res.status = ST_OK;
    res.payload_addr = 16'(pos + HDR_BYTES);
    res.real_len = 16'(hdr_peek(pos, W_LEN, unknown));
    res.ftype = 8'(hdr_peek(pos, W_TYPE, unknown));
    res.timestamp = {hdr_peek(pos, W_TS_HI, unknown), hdr_peek(pos, W_TS_LO, unknown)};
    res.playtime = hdr_peek(pos, W_PLAY, unknown);
    res.codec_tag = {8'(hdr_peek(pos, W_TAG_HI, unknown)),
                     hdr_peek(pos, W_TAG_LO, unknown)};
    prev = hdr_peek(pos, W_NEXT, unknown);
    if (unknown) return 1'b0;
    rd_pos[r] = prev;
    rd_seq[r] = seq + 1;
    rd_resync[r] = rs;
    return 1'b1;
  endfunction

  // returns 0 when the action would touch a header word never stored
  function automatic bit ring_predict(ring_item_t it, output ring_result_t res);
    int r;
    res = '{default: '0};
    r = it.reader;
    case (it.action)
      ACT_WRITE: frame_store(it, res);
      ACT_READ: if (!frame_fetch(r, it, res)) return 1'b0;
      ACT_ATTACH: begin
        res.status = ST_NO_SLOT;
        for (int i = 0; i < SLOTS; i++)
          if (!slot_taken[i]) begin
            slot_taken[i] = 1'b1;
            rd_resync[i] = 1'b1;
            res.status = ST_OK;
            res.assigned_reader = 4'(i);
            break;
          end
      end
      ACT_RELEASE: slot_taken[r] = 1'b0;
      ACT_RESET: ring_clear();
      default: ;
    endcase
    res.write_count = frames_done;
    res.read_count = rd_seq[r];
    return 1'b1;
  endfunction

  // random item with every field filled
  function automatic ring_item_t rand_item(logic [2:0] act);
    ring_item_t it;
    int         pick;
    it.action = act;
    it.reader = 4'($urandom_range(0, SLOTS - 1));
    pick = $urandom_range(0, 99);
    if (pick < 70) it.frame_len = 16'($urandom_range(0, 300));
    else if (pick < 90) it.frame_len = 16'($urandom_range(300, 4000));
    else if (pick < 98) it.frame_len = 16'($urandom_range(4000, 30000));
    else it.frame_len = 16'($urandom_range(60000, 65488));
    it.ftype = ($urandom_range(0, 2) == 0) ? keyframe_code : 8'($urandom);
    it.timestamp = {$urandom, $urandom};
    it.playtime = $urandom;
    it.codec_tag = {8'($urandom), $urandom};
    if ($urandom_range(0, 3) == 0) it.codec_tag[8*$urandom_range(0, 4) +: 8] = 8'd0;
    pick = $urandom_range(0, 99);
    if (pick < 10) it.read_capacity = 17'($urandom_range(0, 512));
    else if (pick < 30) it.read_capacity = 17'd65536;
    else it.read_capacity = 17'($urandom_range(4096, 65536));
    return it;
  endfunction

  // offer one transaction; entered and left at a rising edge
  task automatic send_item(ring_item_t it);
    ring_result_t res;
    int           gap, pick;
    if (!ring_predict(it, res)) begin
      it.action = ACT_QUERY;
      void'(ring_predict(it, res));
    end
    expected_results.push_back(res);
    gap = 0;
    if (!calm) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) gap = 0;
      else if (pick < 94) gap = $urandom_range(1, 3);
      else gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_action <= it.action;
    in_reader <= it.reader;
    in_frame_len <= it.frame_len;
    in_ftype <= it.ftype;
    in_timestamp <= it.timestamp;
    in_playtime <= it.playtime;
    in_codec_tag <= it.codec_tag;
    in_read_capacity <= it.read_capacity;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_op(logic [2:0] act, logic [3:0] rdr);
    ring_item_t it;
    it = rand_item(act);
    it.reader = rdr;
    send_item(it);
  endtask

  task automatic send_frame(logic [15:0] len, logic [7:0] ftype);
    ring_item_t it;
    it = rand_item(ACT_WRITE);
    it.frame_len = len;
    it.ftype = ftype;
    send_item(it);
  endtask

  task automatic send_fetch(logic [3:0] rdr, logic [16:0] cap);
    ring_item_t it;
    it = rand_item(ACT_READ);
    it.reader = rdr;
    it.read_capacity = cap;
    send_item(it);
  endtask

  // stop offering and wait for every outstanding result
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keyframe_code(logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    keyframe_code = v;
  endtask

  // extremes of the fields and every action
  task automatic test_directed();
    ring_item_t it;
    send_op(ACT_QUERY, 4'd0);
    send_fetch(4'd0, 17'd65536);
    send_op(ACT_ATTACH, 4'd0);
    it = rand_item(ACT_WRITE);
    it.frame_len = 16'd0;
    it.ftype = 8'hff;
    it.timestamp = '1;
    it.playtime = '1;
    it.codec_tag = '1;
    send_item(it);
    it.frame_len = 16'd5;
    it.ftype = keyframe_code;
    it.timestamp = '0;
    it.playtime = '0;
    it.codec_tag = 40'h41_00_43_42_41;
    send_item(it);
    send_frame(16'd1, 8'd0);
    send_fetch(4'd0, 17'd0);
    send_fetch(4'd0, 17'd65536);
    send_fetch(4'd0, 17'd65536);
    send_fetch(4'd0, 17'd65536);
    send_op(3'd6, 4'd15);
    send_op(3'd7, 4'd0);
    send_op(ACT_RELEASE, 4'd0);
    send_fetch(4'd0, 17'd65536);
    send_op(ACT_RESET, 4'd0);
    send_op(ACT_QUERY, 4'd15);
    send_fetch(4'd0, 17'd65536);
  endtask

  // every slot taken, one attach too many, then the even slots released
  task automatic test_slot_exhaust();
    for (int i = 0; i <= SLOTS; i++) send_op(ACT_ATTACH, 4'd0);
    for (int i = 0; i < SLOTS; i += 2) send_op(ACT_RELEASE, 4'(i));
  endtask

  // wrap to 0, an overrunning write and a frame that fills the whole ring
  task automatic test_wrap_overrun();
    send_op(ACT_RESET, 4'd0);
    send_frame(16'd100, keyframe_code);
    send_fetch(4'd1, 17'd65536);
    send_frame(16'd30000, 8'd9);
    send_frame(16'd30000, keyframe_code);
    send_frame(16'd3000, 8'd9);
    send_fetch(4'd1, 17'd65536);
    send_fetch(4'd1, 17'd65536);
    send_frame(16'd65488, keyframe_code);
    send_frame(16'd7, 8'd9);
    send_fetch(4'd1, 17'd65536);
    send_fetch(4'd1, 17'd65536);
    send_op(ACT_QUERY, 4'd1);
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    hold_req = 1'b1;
    calm = 1'b1;
    for (int i = 0; i < 40; i++) begin
      if (i % 3 == 2) send_fetch(4'd1, 17'd65536);
      else send_frame(16'($urandom_range(0, 200)), 8'($urandom_range(0, 2)));
    end
    calm = 1'b0;
  endtask

  // mostly writes and reads of attached slots, some noise
  task automatic test_random_traffic(int n);
    ring_item_t it;
    int         pick, busy [$];
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 36) it = rand_item(ACT_WRITE);
      else if (pick < 76) it = rand_item(ACT_READ);
      else if (pick < 82) it = rand_item(ACT_ATTACH);
      else if (pick < 87) it = rand_item(ACT_RELEASE);
      else if (pick < 90) it = rand_item(ACT_RESET);
      else if (pick < 96) it = rand_item(ACT_QUERY);
      else it = rand_item(3'($urandom_range(6, 7)));
      // reset once more than 60 frames are stored, to keep the walk back short
      if (frames_done > 60) it.action = ACT_RESET;
      busy.delete();
      for (int i = 0; i < SLOTS; i++) if (slot_taken[i]) busy.push_back(i);
      if (busy.size() != 0 && $urandom_range(0, 3) != 0)
        it.reader = 4'(busy[$urandom_range(0, busy.size() - 1)]);
      calm = (k % 200) >= 170;
      send_item(it);
    end
    calm = 1'b0;
  endtask

  // receiver side stall pattern
  initial begin
    int left;
    int pick;
    left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        left = 0;
      end
      if (left == 0) begin
        pick = $urandom_range(0, 99);
        if (calm || pick < 55) begin
          out_stall <= 1'b0;
          left = $urandom_range(1, 12);
        end else if (pick < 93) begin
          out_stall <= 1'b1;
          left = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          left = $urandom_range(20, 80);
        end
      end
      left--;
    end
  end

  task automatic check_field(string nm, logic [63:0] e, logic [63:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0h actual %0h", $time, nm, e, a);
      mismatch_count++;
    end
  endtask

  // compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    ring_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result status %0h", $time, out_status);
        mismatch_count++;
      end else begin
        e = expected_results.pop_front();
        check_field("status", 64'(e.status), 64'(out_status));
        check_field("payload_addr", 64'(e.payload_addr), 64'(out_payload_addr));
        check_field("real_len", 64'(e.real_len), 64'(out_real_len));
        check_field("type", 64'(e.ftype), 64'(out_type));
        check_field("timestamp", e.timestamp, out_timestamp);
        check_field("playtime", 64'(e.playtime), 64'(out_playtime));
        check_field("codec_tag", 64'(e.codec_tag), 64'(out_codec_tag));
        check_field("assigned_reader", 64'(e.assigned_reader),
                    64'(out_assigned_reader));
        check_field("write_count", 64'(e.write_count), 64'(out_write_count));
        check_field("read_count", 64'(e.read_count), 64'(out_read_count));
      end
    end
  end

  initial begin
    #100_000_000;
    $display("multi_reader_frame_ring_top: mismatch");
    $finish;
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = '0;
    in_reader = '0;
    in_frame_len = '0;
    in_ftype = '0;
    in_timestamp = '0;
    in_playtime = '0;
    in_codec_tag = '0;
    in_read_capacity = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    calm = 1'b0;
    hold_req = 1'b0;
    mismatch_count = 0;
    for (int i = 0; i < SLOTS; i++) slot_taken[i] = 1'b0;
    ring_clear();
    keyframe_code = 8'd1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_slot_exhaust();
    test_wrap_overrun();
    write_keyframe_code(8'd0);
    test_directed();
    test_backpressure();
    write_keyframe_code(8'd255);
    test_random_traffic(250);
    write_keyframe_code(8'($urandom));
    test_random_traffic(250);
    write_keyframe_code(8'd0);
    test_random_traffic(250);
    write_keyframe_code(8'd1);
    test_random_traffic(250);
    drain();
    repeat (30) @(posedge clk);
    if (mismatch_count == 0) $display("multi_reader_frame_ring_top: match");
    else $display("multi_reader_frame_ring_top: mismatch");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/mrfr_pkg.sv
hw/rtl/mrfr_hdr_store.sv
hw/rtl/multi_reader_frame_ring_top.sv
test/tb_multi_reader_frame_ring_top.sv
